/* rtl/core/ssm_pkg.sv */
// ssm_pkg: shared types, constants and exponential lookup tables for the
// stable softmax vector block. No dependencies.
`timescale 1ns / 1ps

package ssm_pkg;

    localparam int SCORE_W = 16;
    localparam int PROB_W  = 17;
    localparam int SUM_W   = 23;
    localparam int NUM_W   = 33;

    localparam logic [15:0] DIFF_CLAMP = 16'd4096;
    localparam logic [33:0] ROUND_HALF = 34'd32768;

    typedef struct packed {
        logic busy;
        logic done;
    } ssm_div_stat_t;

    // e^-i in Q1.16, i = 0..16
    function automatic logic [16:0] exp_int(input logic [4:0] i);
        logic [16:0] v;
        case (i)
            5'd0:    v = 17'd65536;
            5'd1:    v = 17'd24109;
            5'd2:    v = 17'd8869;
            5'd3:    v = 17'd3263;
            5'd4:    v = 17'd1200;
            5'd5:    v = 17'd442;
            5'd6:    v = 17'd162;
            5'd7:    v = 17'd60;
            5'd8:    v = 17'd22;
            5'd9:    v = 17'd8;
            5'd10:   v = 17'd3;
            5'd11:   v = 17'd1;
            default: v = 17'd0;
        endcase
        return v;
    endfunction

    // e^(-h/16) in Q1.16
    function automatic logic [16:0] exp_hi(input logic [3:0] h);
        logic [16:0] v;
        case (h)
            4'd0:    v = 17'd65536;
            4'd1:    v = 17'd61565;
            4'd2:    v = 17'd57836;
            4'd3:    v = 17'd54331;
            4'd4:    v = 17'd51040;
            4'd5:    v = 17'd47947;
            4'd6:    v = 17'd45042;
            4'd7:    v = 17'd42313;
            4'd8:    v = 17'd39750;
            4'd9:    v = 17'd37341;
            4'd10:   v = 17'd35079;
            4'd11:   v = 17'd32954;
            4'd12:   v = 17'd30957;
            4'd13:   v = 17'd29081;
            4'd14:   v = 17'd27319;
            default: v = 17'd25664;
        endcase
        return v;
    endfunction

    // e^(-l/256) in Q1.16
    function automatic logic [16:0] exp_lo(input logic [3:0] l);
        logic [16:0] v;
        case (l)
            4'd0:    v = 17'd65536;
            4'd1:    v = 17'd65280;
            4'd2:    v = 17'd65026;
            4'd3:    v = 17'd64772;
            4'd4:    v = 17'd64520;
            4'd5:    v = 17'd64268;
            4'd6:    v = 17'd64018;
            4'd7:    v = 17'd63768;
            4'd8:    v = 17'd63520;
            4'd9:    v = 17'd63272;
            4'd10:   v = 17'd63025;
            4'd11:   v = 17'd62780;
            4'd12:   v = 17'd62535;
            4'd13:   v = 17'd62291;
            4'd14:   v = 17'd62048;
            default: v = 17'd61806;
        endcase
        return v;
    endfunction

endpackage

/* rtl/core/stable_softmax_vector.sv */
// stable_softmax_vector: numerically stable fixed-point softmax over a vector.
// Depends on ssm_pkg and ssm_div.
`timescale 1ns / 1ps

// Usage:
//   Input channel (s_valid/s_ready): one Q8.8 score per beat, s_last_in on
//   the final beat of a vector. Scores are stored in a score memory while
//   the running maximum is tracked; one beat is taken per cycle while loading.
//   Beats beyond SEQ_MAX are dropped; the vector still ends on its last mark
//   and every result of that vector carries m_dropped.
//   After the last beat s_ready falls until all results are delivered.
//   Exponent pass: per stored score, a memory read and two table
//   multiplies; results written to an exp memory and summed.
//   Output pass: per score, one memory read, one divider start, 33 steps of
//   the bit-serial divider and a wait state that sees it finish, then the
//   result register holds one beat on m_valid/m_ready; the next score is
//   read only after the receiver takes that result.
//   m_last_out marks the final probability of the vector.
//   A stalled receiver holds the result register and the whole sequencer.
//   Synchronous active-low reset clears the sequencer, fill count, maximum,
//   sum and drop flag; the memories are not cleared and need not be.

module stable_softmax_vector #(
    parameter int SEQ_MAX = 64
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic signed [15:0]          s_score,
    input  logic                        s_last_in,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [16:0]                 m_prob,
    output logic                        m_last_out,
    output logic                        m_dropped
);

    localparam int CW = $clog2(SEQ_MAX + 1);
    localparam int AW = (SEQ_MAX > 1) ? $clog2(SEQ_MAX) : 1;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_EXP_RD,
        ST_EXP_M1,
        ST_EXP_M2,
        ST_NRM_RD,
        ST_NRM_GO,
        ST_NRM_WAIT,
        ST_NRM_OUT
    } state_t;

    state_t                         state_reg;
    logic [CW-1:0]                  fill_reg;
    logic [CW-1:0]                  k_reg;
    logic signed [15:0]             max_reg;
    logic [ssm_pkg::SUM_W-1:0]      sum_reg;
    logic                           ovf_reg;

    logic signed [15:0]             score_mem [SEQ_MAX];
    logic [16:0]                    exp_mem   [SEQ_MAX];
    logic signed [15:0]             score_rd_reg;
    logic [16:0]                    exp_rd_reg;

    logic [16:0]                    e1_reg;
    logic [3:0]                     lo_reg;
    logic [16:0]                    e2;

    logic                           m_valid_reg;
    logic [16:0]                    m_prob_reg;
    logic                           m_last_reg;
    logic                           m_drop_reg;

    logic                           div_start;
    ssm_pkg::ssm_div_stat_t         div_stat;
    logic [16:0]                    div_quot;

    logic                           s_acc;
    logic                           room;
    logic [16:0]                    diff;
    logic [15:0]                    d_clamp;
    logic [33:0]                    prod1;
    logic [33:0]                    prod2;

    assign s_ready = (state_reg == ST_LOAD);
    assign s_acc   = s_valid && s_ready;
    assign room    = fill_reg < CW'(SEQ_MAX);

    // difference to the maximum (maximum minus score), clamped to 16
    assign diff    = 17'({max_reg[15], max_reg}) - 17'({score_rd_reg[15], score_rd_reg});
    assign d_clamp = (diff[15:0] > ssm_pkg::DIFF_CLAMP) ? ssm_pkg::DIFF_CLAMP : diff[15:0];
    assign prod1   = 34'(ssm_pkg::exp_int(d_clamp[12:8])) * 34'(ssm_pkg::exp_hi(d_clamp[7:4]))
                   + ssm_pkg::ROUND_HALF;
    assign prod2   = 34'(e1_reg) * 34'(ssm_pkg::exp_lo(lo_reg)) + ssm_pkg::ROUND_HALF;
    assign e2      = prod2[32:16];

    assign div_start = (state_reg == ST_NRM_GO);

    ssm_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     ({exp_rd_reg, 16'd0}),
        .den     (sum_reg),
        .stat    (div_stat),
        .quot    (div_quot)
    );

    // memories: one write port, registered read
    always_ff @(posedge aclk) begin
        if (s_acc && room) begin
            score_mem[fill_reg[AW-1:0]] <= s_score;
        end
        if (state_reg == ST_EXP_M2) begin
            exp_mem[k_reg[AW-1:0]] <= e2;
        end
        score_rd_reg <= score_mem[k_reg[AW-1:0]];
        exp_rd_reg   <= exp_mem[k_reg[AW-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_LOAD;
            fill_reg    <= '0;
            k_reg       <= '0;
            max_reg     <= 16'sh8000;
            sum_reg     <= '0;
            ovf_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            case (state_reg)
                ST_LOAD: begin
                    if (s_acc) begin
                        if (room) begin
                            fill_reg <= fill_reg + CW'(1);
                            if (s_score > max_reg) begin
                                max_reg <= s_score;
                            end
                        end else begin
                            ovf_reg <= 1'b1;
                        end
                        if (s_last_in) begin
                            k_reg     <= '0;
                            sum_reg   <= '0;
                            state_reg <= ST_EXP_RD;
                        end
                    end
                end
                ST_EXP_RD: begin
                    state_reg <= ST_EXP_M1;
                end
                ST_EXP_M1: begin
                    e1_reg    <= prod1[32:16];
                    lo_reg    <= d_clamp[3:0];
                    state_reg <= ST_EXP_M2;
                end
                ST_EXP_M2: begin
                    sum_reg <= ssm_pkg::SUM_W'(sum_reg + ssm_pkg::SUM_W'(e2));
                    if (k_reg + CW'(1) == fill_reg) begin
                        k_reg     <= '0;
                        state_reg <= ST_NRM_RD;
                    end else begin
                        k_reg     <= k_reg + CW'(1);
                        state_reg <= ST_EXP_RD;
                    end
                end
                ST_NRM_RD: begin
                    state_reg <= ST_NRM_GO;
                end
                ST_NRM_GO: begin
                    state_reg <= ST_NRM_WAIT;
                end
                ST_NRM_WAIT: begin
                    if (div_stat.done) begin
                        m_valid_reg <= 1'b1;
                        m_prob_reg  <= div_quot;
                        m_last_reg  <= (k_reg + CW'(1) == fill_reg);
                        m_drop_reg  <= ovf_reg;
                        state_reg   <= ST_NRM_OUT;
                    end
                end
                ST_NRM_OUT: begin
                    if (m_ready) begin
                        m_valid_reg <= 1'b0;
                        if (m_last_reg) begin
                            // vector done: drop back to reset values
                            fill_reg  <= '0;
                            max_reg   <= 16'sh8000;
                            sum_reg   <= '0;
                            ovf_reg   <= 1'b0;
                            k_reg     <= '0;
                            state_reg <= ST_LOAD;
                        end else begin
                            k_reg     <= k_reg + CW'(1);
                            state_reg <= ST_NRM_RD;
                        end
                    end
                end
                default: begin
                    state_reg <= ST_LOAD;
                end
            endcase
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_prob     = m_prob_reg;
    assign m_last_out = m_last_reg;
    assign m_dropped  = m_drop_reg;

    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= CW'(SEQ_MAX))
        else $error("fill count above capacity");

    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("input taken while a result is pending");

    a_div_done: assert property (@(posedge aclk) disable iff (!aresetn)
        div_stat.done |-> (state_reg == ST_NRM_WAIT))
        else $error("divider finished outside the output pass");

    a_last_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && m_last_out) |=> (fill_reg == '0 && !ovf_reg))
        else $error("vector state not cleared after last result");

endmodule

/* rtl/core/ssm_div.sv */
// ssm_div: restoring divider, one quotient bit per cycle, 33 steps.
// Depends on ssm_pkg for widths and the status struct.
`timescale 1ns / 1ps

module ssm_div (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [ssm_pkg::NUM_W-1:0]   num,
    input  logic [ssm_pkg::SUM_W-1:0]   den,
    output ssm_pkg::ssm_div_stat_t      stat,
    output logic [ssm_pkg::PROB_W-1:0]  quot
);

    logic                       busy_reg;
    logic                       done_reg;
    logic [5:0]                 step_reg;
    logic [ssm_pkg::NUM_W-1:0]  q_reg;
    logic [ssm_pkg::SUM_W-1:0]  rem_reg;
    logic [ssm_pkg::SUM_W-1:0]  den_reg;
    logic [ssm_pkg::SUM_W:0]    rem_shift;
    logic                       fits;

    assign rem_shift = {rem_reg, q_reg[ssm_pkg::NUM_W-1]};
    assign fits      = rem_shift >= {1'b0, den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= 6'd0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                step_reg <= 6'd0;
                q_reg    <= num;
                rem_reg  <= '0;
                den_reg  <= den;
            end else if (busy_reg) begin
                // shift in one numerator bit, subtract where the divisor fits
                rem_reg <= fits ? ssm_pkg::SUM_W'(rem_shift - {1'b0, den_reg})
                                : rem_shift[ssm_pkg::SUM_W-1:0];
                q_reg   <= {q_reg[ssm_pkg::NUM_W-2:0], fits};
                step_reg <= step_reg + 6'd1;
                if (step_reg == 6'(ssm_pkg::NUM_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // a zero divisor gives zero
    assign quot = (den_reg == '0) ? '0 : q_reg[ssm_pkg::PROB_W-1:0];
    assign stat = '{busy: busy_reg, done: done_reg};

endmodule

/* tb/stable_softmax_vector_tb.sv */
// stable_softmax_vector_tb: self-checking bench for the fixed-point softmax block.
// Depends on stable_softmax_vector; predicts results in place.
`timescale 1ns / 1ps

module stable_softmax_vector_tb;

    localparam int VEC_CAP   = 64;
    localparam int CYC_LIMIT = 2000000;

    // score patterns for generated vectors
    localparam int MODE_RAND    = 0;
    localparam int MODE_NARROW  = 1;
    localparam int MODE_EXTREME = 2;
    localparam int MODE_WIDE    = 3;

    // tables for e^-i, e^(-h/16), e^(-l/256) in Q1.16
    localparam logic [16:0] E_INT [0:16] = '{65536, 24109, 8869, 3263, 1200, 442, 162,
        60, 22, 8, 3, 1, 0, 0, 0, 0, 0};
    localparam logic [16:0] E_HI [0:15] = '{65536, 61565, 57836, 54331, 51040, 47947,
        45042, 42313, 39750, 37341, 35079, 32954, 30957, 29081, 27319, 25664};
    localparam logic [16:0] E_LO [0:15] = '{65536, 65280, 65026, 64772, 64520, 64268,
        64018, 63768, 63520, 63272, 63025, 62780, 62535, 62291, 62048, 61806};

    typedef struct packed {
        logic signed [15:0] score;
        logic               last_in;
    } score_beat_t;

    typedef struct packed {
        logic [16:0] prob;
        logic        last_out;
        logic        dropped;
    } prob_beat_t;

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic signed [15:0] s_score;
    logic               s_last_in;
    logic               m_valid;
    logic               m_ready;
    logic [16:0]        m_prob;
    logic               m_last_out;
    logic               m_dropped;

    stable_softmax_vector u_top (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_score    (s_score),
        .s_last_in  (s_last_in),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_prob     (m_prob),
        .m_last_out (m_last_out),
        .m_dropped  (m_dropped)
    );

    // predictor state: the scores of the open vector and the drop flag
    logic signed [15:0] vec_scores [$];
    logic               vec_overflow;

    score_beat_t pending_scores [$];
    prob_beat_t  expected_probs [$];
    int          fail_count;
    int          prob_count;
    int          vector_count;
    int          cycle_count;
    bit          stim_done;

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // e^(-d) in Q1.16 with d in Q8.8, clamped at a difference of 16
    function automatic logic [16:0] exp_of_gap(input logic [16:0] gap);
        logic [16:0] d;
        logic [33:0] e;
        d = (gap > 17'd4096) ? 17'd4096 : gap;
        e = 34'(E_INT[d[12:8]]);
        e = (e * E_HI[d[7:4]] + 34'd32768) >> 16;
        e = (e * E_LO[d[3:0]] + 34'd32768) >> 16;
        return e[16:0];
    endfunction

    // absorb one score; on a last mark queue one probability per stored score
    task automatic predict_softmax(input score_beat_t b);
        logic signed [15:0] peak;
        logic [16:0]        exps [$];
        logic [22:0]        total;
        logic [39:0]        quot;
        prob_beat_t         r;
        int                 n;
        if (vec_scores.size() < VEC_CAP) vec_scores.push_back(b.score);
        else vec_overflow = 1'b1;
        if (!b.last_in) return;
        n = vec_scores.size();
        peak = -16'sd32768;
        foreach (vec_scores[k]) if (vec_scores[k] > peak) peak = vec_scores[k];
        total = '0;
        foreach (vec_scores[k]) begin
            exps.push_back(exp_of_gap(17'($signed(17'(peak)) - $signed(17'(vec_scores[k])))));
            total = total + 23'(exps[k]);
        end
        for (int k = 0; k < n; k++) begin
            quot = (total == 0) ? '0 : (40'(exps[k]) << 16) / 40'(total);
            r.prob     = quot[16:0];
            r.last_out = (k == n - 1);
            r.dropped  = vec_overflow;
            expected_probs.push_back(r);
        end
        vector_count++;
        vec_scores.delete();
        vec_overflow = 1'b0;
    endtask

    // queue one vector of the given length with the given score mode
    task automatic queue_vector(input int len, input int mode);
        score_beat_t b;
        for (int k = 0; k < len; k++) begin
            case (mode)
                MODE_RAND:    b.score = 16'($urandom);
                MODE_NARROW:  b.score = 16'($urandom_range(0, 1023)) - 16'sd512;
                MODE_EXTREME: b.score = (k % 2) ? 16'h8000 : 16'h7FFF;
                default:      b.score = 16'($urandom_range(0, 8191)) - 16'sd4096;
            endcase
            b.last_in = (k == len - 1);
            pending_scores.push_back(b);
        end
    endtask

    initial begin
        score_beat_t b;
        vec_overflow = 1'b0;
        fail_count   = 0;
        prob_count   = 0;
        vector_count = 0;
        stim_done    = 1'b0;
        // directed: single score, extremes, gaps past the clamp, equal scores
        b = '{16'sh7FFF, 1'b1}; pending_scores.push_back(b);
        b = '{-16'sd32768, 1'b1}; pending_scores.push_back(b);
        queue_vector(2, MODE_EXTREME);
        b = '{16'sd0, 1'b0}; pending_scores.push_back(b);
        b = '{16'sd0, 1'b0}; pending_scores.push_back(b);
        b = '{16'sd0, 1'b1}; pending_scores.push_back(b);
        b = '{16'sd4096, 1'b0}; pending_scores.push_back(b);
        b = '{16'sd0, 1'b0}; pending_scores.push_back(b);
        b = '{16'sd1, 1'b0}; pending_scores.push_back(b);
        b = '{16'shFFFF, 1'b0}; pending_scores.push_back(b);
        b = '{16'sh5555, 1'b0}; pending_scores.push_back(b);
        b = '{-16'sh2AAB, 1'b1}; pending_scores.push_back(b);
        // overflow: full store plus dropped tail, last mark on a dropped score
        queue_vector(VEC_CAP + 3, MODE_NARROW);
        // exactly full, no drop
        queue_vector(VEC_CAP, MODE_WIDE);
        // random: mostly short vectors of mixed spread
        while (pending_scores.size() < 150)
            queue_vector($urandom_range(1, 8), $urandom_range(MODE_RAND, MODE_WIDE));
        queue_vector(VEC_CAP + $urandom_range(1, 4), MODE_RAND);
    end

    int burst_left;
    int gap_left;

    // present the next pending beat and advance the burst pattern
    task automatic b_drive();
        score_beat_t nb;
        nb = pending_scores[0];
        s_valid   <= 1'b1;
        s_score   <= nb.score;
        s_last_in <= nb.last_in;
        if (burst_left == 0) begin
            burst_left <= $urandom_range(1, 20);
            gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
        end else begin
            burst_left <= burst_left - 1;
        end
    endtask

    // drive scores in bursts with random gaps
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid    <= 1'b0;
            s_score    <= '0;
            s_last_in  <= 1'b0;
            burst_left <= 0;
            gap_left   <= 0;
        end else if (!s_valid || s_ready) begin
            // the beat on the bus, if any, was accepted at this edge
            if (s_valid) begin
                predict_softmax('{s_score, s_last_in});
                void'(pending_scores.pop_front());
            end
            if (gap_left > 0) begin
                s_valid  <= 1'b0;
                gap_left <= gap_left - 1;
            end else if (pending_scores.size() > 0) begin
                b_drive();
            end else begin
                s_valid <= 1'b0;
                stim_done <= 1'b1;
            end
        end
    end

    // receiver stall pattern: phases of always-ready and of random stalls
    int stall_phase;
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready     <= 1'b0;
            stall_phase <= 0;
        end else begin
            stall_phase <= (stall_phase + 1) % 400;
            m_ready     <= (stall_phase < 150) ? 1'b1 : ($urandom_range(0, 2) != 0);
        end
    end

    // check each delivered probability against the oldest prediction
    always @(posedge aclk) begin
        prob_beat_t want;
        if (aresetn && m_valid && m_ready) begin
            prob_count++;
            if (expected_probs.size() == 0) begin
                $error("unexpected result beat: prob %0d", m_prob);
                fail_count++;
            end else begin
                want = expected_probs.pop_front();
                if (m_prob !== want.prob) begin
                    $error("prob: expected %0d, got %0d", want.prob, m_prob);
                    fail_count++;
                end
                if (m_last_out !== want.last_out) begin
                    $error("last_out: expected %0d, got %0d", want.last_out, m_last_out);
                    fail_count++;
                end
                if (m_dropped !== want.dropped) begin
                    $error("dropped: expected %0d, got %0d", want.dropped, m_dropped);
                    fail_count++;
                end
            end
        end
    end

    // hold reset, then wait for the stimulus to drain
    initial begin
        aresetn     = 1'b0;
        cycle_count = 0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        while (!(stim_done && expected_probs.size() == 0) && cycle_count < CYC_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        if (cycle_count >= CYC_LIMIT) begin
            $display("timeout with %0d results outstanding", expected_probs.size());
            $display("RESULT: ERROR");
            $finish;
        end else begin
            // let any stray beats surface
            repeat (200) @(posedge aclk);
            if (expected_probs.size() != 0 || vec_scores.size() != 0) fail_count++;
            $display("covered %0d vectors, %0d probabilities checked, %0d mismatches",
                     vector_count, prob_count, fail_count);
            if (fail_count == 0) begin
                $display("RESULT: OK");
            end else begin
                $display("RESULT: ERROR");
            end
            $finish;
        end
    end
endmodule
